>>> design/srtf_process_scheduler_assert.svh
// assertion macros used by the scheduler top
`ifndef SRTF_PROCESS_SCHEDULER_ASSERT_SVH
`define SRTF_PROCESS_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent holds -> consequent holds in the same cycle
`define SRTF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srtf check failed: same-cycle implication");

// antecedent holds -> consequent holds in the next cycle
`define SRTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srtf check failed: next-cycle implication");

`else

`define SRTF_ASSERT_SAME(label, clk, rst, ante, cons)
`define SRTF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/srtf_pkg.sv
// types and constants of the shortest-remaining-time-first scheduler
package srtf_pkg;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [15:0] proc_id;
      logic [15:0] burst;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        ran_valid;
      logic [15:0] ran_id;
      logic        finished;
      logic [31:0] wait_time;
      logic [31:0] turnaround;
      logic [31:0] time_now;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] remaining;
      logic [15:0] burst;
      logic [31:0] arrival;
      logic [31:0] sequence_no;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> design/srtf_ram.sv
// generic single-port-write, registered-read RAM
module srtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/srtf_process_scheduler.sv
// srtf scheduler top: process table in RAM, sequential minimum scan per tick
// arrive item or idle tick: no scan, the result goes to S_EMIT and leaves once the output is free
// tick with a busy table: S_SCAN, S_LAST, S_UPDATE, S_WAIT, then S_EMIT, before the next item
//   is accepted (one RAM read per slot over all MAX_PROCS slots, then update and emit)
// the scan is bound by the single RAM read port, one slot per cycle
// synchronous reset empties the table (valid flops) and zeroes time and sequence
module srtf_process_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srtf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srtf_pkg::rsp_type rsp_data
);
   import srtf_pkg::*;

`include "srtf_process_scheduler_assert.svh"

   localparam int SLOT_W = $clog2(MAX_PROCS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_UPDATE,
      S_WAIT,
      S_EMIT
   } state_type;

   state_type             state_ff;
   logic [MAX_PROCS-1:0]  valid_ff;
   logic [31:0]           time_ff;
   logic [31:0]           seq_ff;
   logic [SLOT_W-1:0]     rd_addr_ff;
   logic [SLOT_W-1:0]     rd_slot_ff;
   logic                  rd_pend_ff;
   logic                  best_found_ff;
   logic [SLOT_W-1:0]     best_slot_ff;
   entry_type             best_ff;
   logic [31:0]           tat_ff;
   logic                  fin_ff;
   rsp_type               res_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic                  req_acc;
   logic                  free_found;
   logic [SLOT_W-1:0]     free_slot;
   entry_type             cand;
   logic                  cand_better;
   logic [15:0]           new_rem;
   logic                  ram_wr_en;
   logic [SLOT_W-1:0]     ram_wr_addr;
   entry_type             ram_wr_entry;
   logic                  ram_rd_en;
   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [31:0]           time_inc;
   logic                  out_free;
   rsp_type               idle_res;
   logic                  finish_now;
   logic                  refused_out;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign time_inc  = time_ff + 32'd1;
   assign new_rem   = best_ff.remaining - 16'd1;
   assign cand      = entry_type'(ram_rd_data);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = MAX_PROCS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   // result of an item that needs no scan
   always_comb begin
      idle_res          = '0;
      idle_res.status   = ST_OK;
      idle_res.time_now = time_ff;
      if (req_data.opcode == OP_ARRIVE) begin
         if (req_data.burst == 16'd0) begin
            idle_res.status = ST_ZERO;
         end else if (!free_found) begin
            idle_res.status = ST_FULL;
         end
      end else begin
         idle_res.time_now = time_inc;
      end
   end

   // strict compare keeps the lowest slot on a full key tie
   always_comb begin
      cand_better = valid_ff[rd_slot_ff] &&
                    (!best_found_ff ||
                     ({cand.remaining, cand.arrival, cand.sequence_no} <
                      {best_ff.remaining, best_ff.arrival, best_ff.sequence_no}));
   end

   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = free_slot;
      ram_wr_entry = best_ff;
      if (state_ff == S_UPDATE) begin
         ram_wr_en              = 1'b1;
         ram_wr_addr            = best_slot_ff;
         ram_wr_entry.remaining = new_rem;
      end else if (req_acc && req_data.opcode == OP_ARRIVE &&
                   req_data.burst != 16'd0 && free_found) begin
         ram_wr_en                = 1'b1;
         ram_wr_entry.id          = req_data.proc_id;
         ram_wr_entry.remaining   = req_data.burst;
         ram_wr_entry.burst       = req_data.burst;
         ram_wr_entry.arrival     = time_ff;
         ram_wr_entry.sequence_no = seq_ff;
      end
      ram_rd_en = (state_ff == S_SCAN);
   end

   srtf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PROCS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         time_ff       <= '0;
         seq_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_pend_ff <= (state_ff == S_SCAN);
         rd_slot_ff <= rd_addr_ff;

         if (rd_pend_ff && cand_better) begin
            best_ff       <= cand;
            best_slot_ff  <= rd_slot_ff;
            best_found_ff <= 1'b1;
         end

         rsp_valid_ff <= (state_ff == S_EMIT && out_free) || (rsp_valid_ff && rsp_stall);

         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  res_ff <= idle_res;
                  if (req_data.opcode == OP_TICK && |valid_ff) begin
                     rd_addr_ff    <= '0;
                     best_found_ff <= 1'b0;
                     state_ff      <= S_SCAN;
                  end else begin
                     state_ff <= S_EMIT;
                     if (req_data.opcode == OP_TICK) begin
                        // empty table: time still moves
                        time_ff <= time_inc;
                     end else if (req_data.burst != 16'd0 && free_found) begin
                        valid_ff[free_slot] <= 1'b1;
                        seq_ff              <= seq_ff + 32'd1;
                     end
                  end
               end
            end
            S_SCAN: begin
               rd_addr_ff <= rd_addr_ff + SLOT_W'(1);
               if (rd_addr_ff == SLOT_W'(MAX_PROCS - 1)) begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               time_ff <= time_inc;
               tat_ff  <= time_inc - best_ff.arrival;
               fin_ff  <= (new_rem == 16'd0);
               if (new_rem == 16'd0) begin
                  valid_ff[best_slot_ff] <= 1'b0;
               end
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               res_ff.status     <= ST_OK;
               res_ff.ran_valid  <= 1'b1;
               res_ff.ran_id     <= best_ff.id;
               res_ff.finished   <= fin_ff;
               res_ff.time_now   <= time_ff;
               res_ff.turnaround <= fin_ff ? tat_ff : 32'd0;
               if (fin_ff && tat_ff >= {16'd0, best_ff.burst}) begin
                  res_ff.wait_time <= tat_ff - {16'd0, best_ff.burst};
               end else begin
                  res_ff.wait_time <= 32'd0;
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_ff   <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign finish_now  = (state_ff == S_UPDATE) && (new_rem == 16'd0);
   assign refused_out = rsp_valid_ff && (rsp_ff.status != ST_OK);

   `SRTF_ASSERT_SAME(a_update_has_best, clock, reset, state_ff == S_UPDATE, best_found_ff)
   `SRTF_ASSERT_NEXT(a_finish_frees_slot, clock, reset, finish_now, !valid_ff[best_slot_ff])
   `SRTF_ASSERT_SAME(a_finished_ran, clock, reset, rsp_valid_ff && rsp_ff.finished, rsp_ff.ran_valid)
   `SRTF_ASSERT_SAME(a_refusal_no_run, clock, reset, refused_out, !rsp_ff.ran_valid && !rsp_ff.finished)

endmodule
